@@ hdl/dpws_pkg.sv @@
package dpws_pkg;

   localparam int unsigned FIELD_BITS = 16;
   localparam int unsigned STATUS_BITS = 3;

   localparam logic [STATUS_BITS-1:0] STATUS_ADDED  = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_SEEN   = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL   = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_POPPED = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY  = 3'd4;

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_POP = 1'b1;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [FIELD_BITS-1:0]  popped_first;
      logic [FIELD_BITS-1:0]  popped_second;
   } result_type;

endpackage

@@ hdl/dpws_sync_ram.sv @@
module dpws_sync_ram #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned WIDTH = 32,
   parameter int unsigned AW    = 10
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/dedup_pair_worklist_stack.sv @@
// worklist of index pairs with a visited set and a lifo stack
// request channel (req_): tuser carries the operation, add or pop; tdata carries
// the first index in the low half and the second index in the high half
// response channel (rsp_): exactly one response per request; tuser carries the
// status (added, already seen, set full, popped, stack empty); tdata carries the
// popped pair, zero on anything but a successful pop
// an add scans the stored pairs in the visited-set memory one entry per cycle,
// up to all CAPACITY entries when the set is full; a pop reads the stack
// memory and then the visited-set memory; one request is worked at a time
// the response sits in an output register; while the receiver stalls it holds,
// the next request may still be accepted and worked, and its result waits
// until the output register frees up
// reset empties the set and the stack at once (counts cleared, no sweep)
module dedup_pair_worklist_stack
   import dpws_pkg::*;
#(
   parameter int unsigned CAPACITY   = 1024,
   parameter int unsigned INDEX_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // first_index, second_index
   input  logic [0:0]  req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // popped_first, popped_second
   output logic [2:0]  rsp_tuser    // status
);

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned KW = 2 * INDEX_BITS;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_SCAN      = 3'd1;
   localparam logic [2:0] S_POP_STACK = 3'd2;
   localparam logic [2:0] S_POP_SEEN  = 3'd3;
   localparam logic [2:0] S_OUT       = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] seen_count_ff, seen_count_in;
   logic [CW-1:0] stack_depth_ff, stack_depth_in;
   logic [CW-1:0] scan_idx_ff, scan_idx_in;
   logic          cmp_valid_ff, cmp_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [KW-1:0] key_ff, key_in;
   result_type    res_ff, res_in;
   result_type    rsp_ff, rsp_in;

   logic          seen_we, seen_re;
   logic [AW-1:0] seen_waddr, seen_raddr;
   logic [KW-1:0] seen_wdata, seen_rdata;
   logic          stack_we, stack_re;
   logic [AW-1:0] stack_waddr, stack_raddr, stack_rdata;

   logic [INDEX_BITS+FIELD_BITS-1:0] first_ext_in, second_ext_in;
   logic [INDEX_BITS+FIELD_BITS-1:0] first_ext_out, second_ext_out;
   logic [KW-1:0] req_key;
   logic [CW-1:0] depth_dec;
   logic          req_fire, out_free, match;

   dpws_sync_ram #(.DEPTH(CAPACITY), .WIDTH(KW), .AW(AW)) u_seen (
      .clock  (clock),
      .wr_en  (seen_we),
      .wr_addr(seen_waddr),
      .wr_data(seen_wdata),
      .rd_en  (seen_re),
      .rd_addr(seen_raddr),
      .rd_data(seen_rdata)
   );

   dpws_sync_ram #(.DEPTH(CAPACITY), .WIDTH(AW), .AW(AW)) u_stack (
      .clock  (clock),
      .wr_en  (stack_we),
      .wr_addr(stack_waddr),
      .wr_data(seen_count_ff[AW-1:0]),
      .rd_en  (stack_re),
      .rd_addr(stack_raddr),
      .rd_data(stack_rdata)
   );

   // mask or zero-extend the 16-bit fields to INDEX_BITS and back
   assign first_ext_in   = {{INDEX_BITS{1'b0}}, req_tdata[15:0]};
   assign second_ext_in  = {{INDEX_BITS{1'b0}}, req_tdata[31:16]};
   assign req_key        = {first_ext_in[INDEX_BITS-1:0], second_ext_in[INDEX_BITS-1:0]};
   assign first_ext_out  = {{FIELD_BITS{1'b0}}, seen_rdata[KW-1:INDEX_BITS]};
   assign second_ext_out = {{FIELD_BITS{1'b0}}, seen_rdata[INDEX_BITS-1:0]};

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign depth_dec  = stack_depth_ff - 1'b1;
   assign match      = cmp_valid_ff && (seen_rdata == key_ff);

   always_comb begin
      state_in       = state_ff;
      seen_count_in  = seen_count_ff;
      stack_depth_in = stack_depth_ff;
      scan_idx_in    = scan_idx_ff;
      cmp_valid_in   = 1'b0;
      key_in         = key_ff;
      res_in         = res_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      seen_we        = 1'b0;
      seen_waddr     = seen_count_ff[AW-1:0];
      seen_wdata     = key_ff;
      seen_re        = 1'b0;
      seen_raddr     = scan_idx_ff[AW-1:0];
      stack_we       = 1'b0;
      stack_waddr    = stack_depth_ff[AW-1:0];
      stack_re       = 1'b0;
      stack_raddr    = depth_dec[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_tuser[0] == OP_ADD) begin
                  key_in      = req_key;
                  scan_idx_in = '0;
                  state_in    = S_SCAN;
               end else if (stack_depth_ff == '0) begin
                  res_in   = '{status: STATUS_EMPTY, popped_first: '0, popped_second: '0};
                  state_in = S_OUT;
               end else begin
                  stack_re       = 1'b1;
                  stack_depth_in = depth_dec;
                  state_in       = S_POP_STACK;
               end
            end
         end
         S_SCAN: begin
            if (match) begin
               res_in   = '{status: STATUS_SEEN, popped_first: '0, popped_second: '0};
               state_in = S_OUT;
            end else if (scan_idx_ff != seen_count_ff) begin
               seen_re      = 1'b1;
               cmp_valid_in = 1'b1;
               scan_idx_in  = scan_idx_ff + 1'b1;
            end else if (!cmp_valid_ff) begin
               if (seen_count_ff == CW'(CAPACITY)) begin
                  res_in = '{status: STATUS_FULL, popped_first: '0, popped_second: '0};
               end else begin
                  seen_we        = 1'b1;
                  stack_we       = 1'b1;
                  seen_count_in  = seen_count_ff + 1'b1;
                  stack_depth_in = stack_depth_ff + 1'b1;
                  res_in = '{status: STATUS_ADDED, popped_first: '0, popped_second: '0};
               end
               state_in = S_OUT;
            end
         end
         S_POP_STACK: begin
            seen_re    = 1'b1;
            seen_raddr = stack_rdata;
            state_in   = S_POP_SEEN;
         end
         S_POP_SEEN: begin
            res_in = '{status: STATUS_POPPED,
                       popped_first: first_ext_out[FIELD_BITS-1:0],
                       popped_second: second_ext_out[FIELD_BITS-1:0]};
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         seen_count_ff  <= '0;
         stack_depth_ff <= '0;
         cmp_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         seen_count_ff  <= seen_count_in;
         stack_depth_ff <= stack_depth_in;
         cmp_valid_ff   <= cmp_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      key_ff      <= key_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {rsp_ff.popped_second, rsp_ff.popped_first};

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import dpws_pkg::*;

   localparam int unsigned CAPACITY     = 1024;
   localparam int unsigned RANDOM_ITEMS = 440;
   localparam int unsigned HOLD_AFTER   = 200;
   localparam int unsigned HOLD_CYCLES  = 600;
   localparam int unsigned CYCLE_LIMIT  = 5_000_000;

   typedef struct {
      logic       op;
      logic [15:0] first;
      logic [15:0] second;
      bit         typed;
      result_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // first_index, second_index
   logic [0:0]  req_tuser = '0;    // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // popped_first, popped_second
   logic [2:0]  rsp_tuser;         // status

   logic [31:0]  visited_keys[$];   // {first, second}
   int unsigned  open_stack[$];     // positions in visited_keys
   result_type   pending_responses[$];
   stim_row_type directed_rows[$];

   bit          idle_on = 1'b0;
   int unsigned error_count = 0;
   int unsigned responses_seen = 0;
   int unsigned stall_left = 0;
   bit          hold_done = 1'b0;
   int unsigned cycle_count = 0;

   dedup_pair_worklist_stack uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic bit pair_is_visited(logic [31:0] key);
      foreach (visited_keys[i]) begin
         if (visited_keys[i] == key) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic result_type worklist_predict(logic op, logic [15:0] first,
                                                   logic [15:0] second);
      result_type  r;
      logic [31:0] key;
      int unsigned pos;
      r = '0;
      key = {first, second};
      if (op == OP_ADD) begin
         if (pair_is_visited(key)) begin
            r.status = STATUS_SEEN;
         end else if (visited_keys.size() >= CAPACITY) begin
            r.status = STATUS_FULL;
         end else begin
            open_stack.push_back(visited_keys.size());
            visited_keys.push_back(key);
            r.status = STATUS_ADDED;
         end
      end else if (open_stack.size() == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         pos = open_stack.pop_back();
         r.status = STATUS_POPPED;
         r.popped_first = visited_keys[pos][31:16];
         r.popped_second = visited_keys[pos][15:0];
      end
      return r;
   endfunction

   function automatic logic [15:0] pick_index();
      case ($urandom_range(0, 6))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 3));
         3: return 16'h0001 << $urandom_range(0, 15);
         4: return ~(16'h0001 << $urandom_range(0, 15));
         default: return 16'($urandom());
      endcase
   endfunction

   // mostly new pairs, some exact repeats, some near misses on one index
   function automatic logic [31:0] pick_pair();
      logic [31:0] key;
      int unsigned sel;
      sel = $urandom_range(0, 99);
      key = {pick_index(), pick_index()};
      if (sel < 30 && visited_keys.size() != 0) begin
         key = visited_keys[$urandom_range(0, visited_keys.size() - 1)];
         if (sel >= 20) begin
            if ($urandom_range(0, 1) == 1) key[15:0] = pick_index();
            else key[31:16] = pick_index();
         end
      end
      return key;
   endfunction

   function automatic logic [31:0] fresh_pair();
      logic [31:0] key;
      do key = $urandom(); while (pair_is_visited(key));
      return key;
   endfunction

   function automatic logic [31:0] old_pair();
      return visited_keys[$urandom_range(0, visited_keys.size() - 1)];
   endfunction

   task automatic queue_row(logic op, logic [15:0] first, logic [15:0] second, bit typed,
                            logic [2:0] status, logic [15:0] pf, logic [15:0] ps);
      stim_row_type row;
      row.op = op;
      row.first = first;
      row.second = second;
      row.typed = typed;
      row.want.status = status;
      row.want.popped_first = pf;
      row.want.popped_second = ps;
      directed_rows.push_back(row);
   endtask

   task automatic send_request(logic op, logic [15:0] first, logic [15:0] second,
                               bit typed = 1'b0, result_type want = '0);
      result_type predicted;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {second, first};
      do @(posedge clock); while (!req_tready);
      predicted = worklist_predict(op, first, second);
      pending_responses.push_back(typed ? want : predicted);
   endtask

   task automatic send_add(logic [31:0] key);
      send_request(OP_ADD, key[31:16], key[15:0]);
   endtask

   task automatic send_pop();
      send_request(OP_POP, 16'($urandom()), 16'($urandom()));
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // response side: checker, random stalls and one long hold
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            responses_seen++;
            if (pending_responses.size() == 0) begin
               report_mismatch("response with no request pending", 32'(rsp_tuser), 32'd0);
            end else begin
               want = pending_responses.pop_front();
               if (rsp_tuser != want.status)
                  report_mismatch("status", 32'(rsp_tuser), 32'(want.status));
               if (rsp_tdata[15:0] != want.popped_first)
                  report_mismatch("popped_first", 32'(rsp_tdata[15:0]),
                                  32'(want.popped_first));
               if (rsp_tdata[31:16] != want.popped_second)
                  report_mismatch("popped_second", 32'(rsp_tdata[31:16]),
                                  32'(want.popped_second));
            end
         end
         if (!hold_done && responses_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 7);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned n;

      queue_row(OP_POP, 16'h0000, 16'h0000, 1, STATUS_EMPTY,  16'h0000, 16'h0000);
      queue_row(OP_ADD, 16'h0000, 16'h0000, 1, STATUS_ADDED,  16'h0000, 16'h0000);
      queue_row(OP_ADD, 16'h0000, 16'h0000, 1, STATUS_SEEN,   16'h0000, 16'h0000);
      queue_row(OP_ADD, 16'hFFFF, 16'hFFFF, 1, STATUS_ADDED,  16'h0000, 16'h0000);
      queue_row(OP_POP, 16'h1234, 16'h5678, 1, STATUS_POPPED, 16'hFFFF, 16'hFFFF);
      queue_row(OP_ADD, 16'hFFFF, 16'hFFFF, 1, STATUS_SEEN,   16'h0000, 16'h0000);
      queue_row(OP_ADD, 16'h0000, 16'hFFFF, 0, STATUS_ADDED,  16'h0000, 16'h0000);
      queue_row(OP_ADD, 16'hFFFF, 16'h0000, 0, STATUS_ADDED,  16'h0000, 16'h0000);
      queue_row(OP_ADD, 16'h0000, 16'h0001, 0, STATUS_ADDED,  16'h0000, 16'h0000);
      queue_row(OP_ADD, 16'h0001, 16'h0000, 0, STATUS_ADDED,  16'h0000, 16'h0000);
      queue_row(OP_ADD, 16'h0000, 16'hFFFF, 0, STATUS_SEEN,   16'h0000, 16'h0000);
      queue_row(OP_ADD, 16'h5555, 16'hAAAA, 0, STATUS_ADDED,  16'h0000, 16'h0000);
      queue_row(OP_ADD, 16'hAAAA, 16'h5555, 0, STATUS_ADDED,  16'h0000, 16'h0000);
      repeat (7) queue_row(OP_POP, 16'hFFFF, 16'hFFFF, 0, STATUS_POPPED, 16'h0, 16'h0);
      queue_row(OP_POP, 16'hFFFF, 16'hFFFF, 1, STATUS_EMPTY,  16'h0000, 16'h0000);
      queue_row(OP_ADD, 16'h0001, 16'h0000, 1, STATUS_SEEN,   16'h0000, 16'h0000);
      queue_row(OP_ADD, 16'h0000, 16'h0002, 0, STATUS_ADDED,  16'h0000, 16'h0000);
      queue_row(OP_POP, 16'h0000, 16'h0000, 0, STATUS_POPPED, 16'h0000, 16'h0000);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].op, directed_rows[i].first, directed_rows[i].second,
                      directed_rows[i].typed, directed_rows[i].want);

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) idle_on <= ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 99) < 35) send_pop();
         else send_add(pick_pair());
      end

      idle_on <= 1'b0;
      repeat (6) begin
         send_add(fresh_pair());
         send_add(old_pair());
      end
      send_add(32'h0000_0000);
      send_add(32'hFFFF_FFFF);
      while (open_stack.size() != 0) send_pop();
      send_pop();
      send_pop();
      send_add(fresh_pair());
      send_add(visited_keys[0]);
      req_tvalid <= 1'b0;

      while (pending_responses.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/dpws_pkg.sv
hdl/dpws_sync_ram.sv
hdl/dedup_pair_worklist_stack.sv
tb/sv/tb.sv
